[sv/jrdp_pkg.sv]
// ----------------------------------------------------------------------------
// jrdp_pkg
// Shared constants, types and codes for the joint ramp to default pose block.
// ----------------------------------------------------------------------------
package jrdp_pkg;

    localparam int NUM_JOINTS = 12;
    localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam int CW = $clog2(NUM_JOINTS + 1);

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    localparam logic REG_MAX_VEL   = 1'b0;
    localparam logic REG_THRESHOLD = 1'b1;

    localparam logic [14:0] MAX_VEL_RESET   = 15'd6144;
    localparam logic [14:0] THRESHOLD_RESET = 15'd41;
    localparam logic [19:0] US_PER_S        = 20'd1000000;

    // datapath operations
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_STORE    = 4'd1;
    localparam logic [3:0] OP_COPY     = 4'd2;
    localparam logic [3:0] OP_ERR      = 4'd3;
    localparam logic [3:0] OP_DUR_DIV  = 4'd4;
    localparam logic [3:0] OP_DUR_END  = 4'd5;
    localparam logic [3:0] OP_JOINT    = 4'd6;
    localparam logic [3:0] OP_POS_DIV  = 4'd7;
    localparam logic [3:0] OP_VEL_DIV  = 4'd8;
    localparam logic [3:0] OP_EMIT     = 4'd9;
    localparam logic [3:0] OP_TICK_SET = 4'd10;

    typedef struct packed {
        logic [3:0]    op;
        logic [JW-1:0] idx;
        logic          src_cur;
        logic          step;
    } jrdp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic ramp;
    } jrdp_sts_t;

endpackage

[sv/jrdp_datapath.sv]
// ----------------------------------------------------------------------------
// jrdp_datapath
// Position stores, error scan, shared restoring divider and command build.
// ----------------------------------------------------------------------------
module jrdp_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  jrdp_pkg::jrdp_cmd_t   cmd,
    output jrdp_pkg::jrdp_sts_t   sts,
    input  logic [1:0]            req_type,
    input  logic [3:0]            joint_index,
    input  logic signed [15:0]    joint_position,
    input  logic [31:0]           time_us,
    input  logic [14:0]           max_vel,
    input  logic [14:0]           threshold,
    output logic [15:0]           out_position,
    output logic [15:0]           out_velocity,
    output logic                  out_reached
);
    import jrdp_pkg::*;

    logic signed [15:0] dflt_mem [NUM_JOINTS];
    logic signed [15:0] strt_mem [NUM_JOINTS];
    logic signed [15:0] curr_mem [NUM_JOINTS];

    logic [31:0] start_time_reg;
    logic [31:0] duration_reg;
    logic [31:0] elapsed_reg;
    logic [31:0] time_reg;
    logic [16:0] err_reg;
    logic        reached_reg;
    logic        ramp_reg;

    // divider: 56 bit unsigned dividend, 32 bit divisor
    logic [55:0] quo_reg;
    logic [32:0] rem_reg;
    logic [31:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic        neg_reg;
    logic        div_done_reg;

    logic signed [16:0] diff;
    logic [16:0]        adiff;
    logic signed [15:0] dsel;
    logic signed [15:0] osel;
    logic [32:0]        trial;
    logic [32:0]        sub;
    logic signed [56:0] sq;
    logic signed [17:0] vel_clamped;
    logic signed [15:0] vlim;
    logic               in_range;

    assign in_range = ({1'b0, joint_index} < 5'(NUM_JOINTS));
    assign dsel = dflt_mem[cmd.idx];
    assign osel = cmd.src_cur ? curr_mem[cmd.idx] : strt_mem[cmd.idx];
    assign diff = 17'(dsel) - 17'(osel);
    assign adiff = diff[16] ? 17'(-diff) : diff;
    assign trial = {rem_reg[31:0], quo_reg[55]};
    assign sub = trial - {1'b0, dvs_reg};
    assign sq = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign vlim = $signed({1'b0, max_vel});

    always_comb
    begin
        if (sq > 57'(vlim))
            vel_clamped = 18'(vlim);
        else if (sq < -57'(vlim))
            vel_clamped = -18'(vlim);
        else
            vel_clamped = 18'(sq);
    end

    assign sts.div_done = div_done_reg;
    assign sts.ramp = ramp_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_STORE && in_range)
        begin
            case (req_type)
                REQ_LOAD:  dflt_mem[joint_index[JW-1:0]] <= joint_position;
                REQ_START: strt_mem[joint_index[JW-1:0]] <= joint_position;
                REQ_TICK:  curr_mem[joint_index[JW-1:0]] <= joint_position;
                default:   ;
            endcase
        end
        else if (cmd.op == OP_COPY)
            dflt_mem[cmd.idx] <= osel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_time_reg <= '0;
            duration_reg <= '0;
            elapsed_reg <= '0;
            time_reg <= '0;
            err_reg <= '0;
            quo_reg <= '0;
            rem_reg <= '0;
            dvs_reg <= '0;
            cnt_reg <= '0;
            neg_reg <= 1'b0;
            div_done_reg <= 1'b0;
            ramp_reg <= 1'b0;
            reached_reg <= 1'b0;
            out_position <= '0;
            out_velocity <= '0;
            out_reached <= 1'b0;
        end
        else
        begin
            div_done_reg <= 1'b0;
            case (cmd.op)
                OP_STORE:
                    time_reg <= time_us;
                OP_ERR:
                begin
                    if (cmd.step)
                        err_reg <= '0;
                    else if (adiff > err_reg)
                        err_reg <= adiff;
                end
                OP_DUR_DIV, OP_POS_DIV, OP_VEL_DIV:
                begin
                    if (cmd.step)
                    begin
                        cnt_reg <= 6'd56;
                        rem_reg <= '0;
                        if (cmd.op == OP_DUR_DIV)
                        begin
                            quo_reg <= 56'(err_reg) * 56'(US_PER_S);
                            dvs_reg <= 32'(max_vel);
                            neg_reg <= 1'b0;
                        end
                        else
                        begin
                            quo_reg <= (cmd.op == OP_POS_DIV) ?
                                56'(adiff) * 56'(elapsed_reg) :
                                56'(adiff) * 56'(US_PER_S);
                            dvs_reg <= duration_reg;
                            neg_reg <= diff[16];
                        end
                    end
                    else if (cnt_reg != 6'd0)
                    begin
                        if (!sub[32])
                            rem_reg <= sub;
                        else
                            rem_reg <= trial;
                        quo_reg <= {quo_reg[54:0], ~sub[32]};
                        cnt_reg <= cnt_reg - 6'd1;
                        div_done_reg <= (cnt_reg == 6'd1);
                    end
                end
                OP_DUR_END:
                begin
                    start_time_reg <= time_reg;
                    if (max_vel == 15'd0)
                        duration_reg <= '0;
                    else if (quo_reg[55:32] != '0)
                        duration_reg <= '1;
                    else
                        duration_reg <= quo_reg[31:0];
                end
                OP_TICK_SET:
                begin
                    elapsed_reg <= time_reg - start_time_reg;
                    reached_reg <= (err_reg < 17'(threshold));
                    ramp_reg <= !(err_reg < 17'(threshold)) && duration_reg != '0
                        && (time_reg - start_time_reg) < duration_reg;
                end
                OP_JOINT:
                begin
                    out_position <= dsel;
                    out_velocity <= '0;
                    out_reached <= reached_reg;
                end
                OP_EMIT:
                    out_velocity <= 16'(vel_clamped);
                default:
                    ;
            endcase
            if (cmd.op == OP_VEL_DIV && cmd.step)
                out_position <= 16'(osel + 16'(sq));
        end
    end

endmodule

[sv/jrdp_ctrl.sv]
// ----------------------------------------------------------------------------
// jrdp_ctrl
// Sequencer: accepts items, runs group end scans, divisions and emission.
// ----------------------------------------------------------------------------
module jrdp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_fire,
    input  logic [1:0]            req_type,
    input  logic                  last_joint,
    output logic                  in_ready,
    output logic                  res_valid,
    input  logic                  res_taken,
    output logic [3:0]            res_index,
    output logic                  res_last,
    output jrdp_pkg::jrdp_cmd_t   cmd,
    input  jrdp_pkg::jrdp_sts_t   sts
);
    import jrdp_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_COPY   = 4'd1;
    localparam logic [3:0] S_ERR    = 4'd2;
    localparam logic [3:0] S_DDIV   = 4'd3;
    localparam logic [3:0] S_DEND   = 4'd4;
    localparam logic [3:0] S_TSET   = 4'd5;
    localparam logic [3:0] S_JOINT  = 4'd6;
    localparam logic [3:0] S_PDIV   = 4'd7;
    localparam logic [3:0] S_VDIV   = 4'd8;
    localparam logic [3:0] S_EMIT   = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          first_reg, first_next;
    logic          tick_reg, tick_next;
    logic          loaded_reg, loaded_next;
    logic [JW-1:0] idx;

    assign idx = cnt_reg[JW-1:0];
    assign in_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign res_index = 4'(cnt_reg);
    assign res_last = (cnt_reg == CW'(NUM_JOINTS - 1));

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        first_next = 1'b0;
        tick_next = tick_reg;
        loaded_next = loaded_reg;
        cmd.op = OP_NONE;
        cmd.idx = idx;
        cmd.src_cur = tick_reg;
        cmd.step = first_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.op = OP_STORE;
                    if (req_type == REQ_LOAD)
                        loaded_next = 1'b1;
                    if ((req_type == REQ_START || req_type == REQ_TICK) && last_joint)
                    begin
                        tick_next = (req_type == REQ_TICK);
                        cnt_next = '0;
                        first_next = 1'b1;
                        state_next = loaded_reg ? S_ERR : S_COPY;
                        loaded_next = 1'b1;
                    end
                end
            end
            S_COPY:
            begin
                cmd.op = OP_COPY;
                if (cnt_reg == CW'(NUM_JOINTS - 1))
                begin
                    cnt_next = '0;
                    first_next = 1'b1;
                    state_next = S_ERR;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_ERR:
            begin
                cmd.op = OP_ERR;
                if (first_reg)
                    cnt_next = '0;
                else if (cnt_reg == CW'(NUM_JOINTS - 1))
                begin
                    cnt_next = '0;
                    first_next = 1'b1;
                    state_next = tick_reg ? S_TSET : S_DDIV;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_DDIV:
            begin
                cmd.op = OP_DUR_DIV;
                if (sts.div_done)
                    state_next = S_DEND;
            end
            S_DEND:
            begin
                cmd.op = OP_DUR_END;
                state_next = S_IDLE;
            end
            S_TSET:
            begin
                cmd.op = OP_TICK_SET;
                state_next = S_JOINT;
            end
            S_JOINT:
            begin
                cmd.op = OP_JOINT;
                first_next = 1'b1;
                state_next = sts.ramp ? S_PDIV : S_OUT;
            end
            S_PDIV:
            begin
                cmd.op = OP_POS_DIV;
                cmd.src_cur = 1'b0;
                if (sts.div_done)
                begin
                    first_next = 1'b1;
                    state_next = S_VDIV;
                end
            end
            S_VDIV:
            begin
                cmd.op = OP_VEL_DIV;
                cmd.src_cur = 1'b0;
                if (sts.div_done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.op = OP_EMIT;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (res_taken)
                begin
                    if (res_last)
                        state_next = S_IDLE;
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        state_next = S_JOINT;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            first_reg <= 1'b0;
            tick_reg <= 1'b0;
            loaded_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            first_reg <= first_next;
            tick_reg <= tick_next;
            loaded_reg <= loaded_next;
        end
    end

endmodule

[sv/joint_ramp_to_default_pose.sv]
// ----------------------------------------------------------------------------
// joint_ramp_to_default_pose
// Linear joint-space ramp from sampled start positions to default positions.
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_axis    in   tdata: joint_index, joint_position, time_us; tuser: req_type;
//                tlast: last_joint
// m_axis    out  tdata: out_joint_index, cmd_position, cmd_velocity;
//                tuser: target_reached; tlast: last_command
// cfg       in   wr_en, wr_index, wr_data
// Plain items do not stall the input. A start group end runs the error scan and
// the 56-step divider; a tick group end runs the scans, then up to two
// divisions per joint on the shared divider.
// Results are held while m_axis_tready is low; input stalls until done.
// Reset clears control state; position stores are valid once written.
module joint_ramp_to_default_pose (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // joint_index[3:0], joint_position[19:4],
                                       // time_us[51:20], zero fill
    input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // out_joint_index[3:0], cmd_position[19:4],
                                       // cmd_velocity[35:20], zero fill
    output logic        m_axis_tuser,  // target_reached
    output logic        m_axis_tlast,
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [14:0] wr_data
);
    import jrdp_pkg::*;

    logic [14:0] max_vel_reg;
    logic [14:0] threshold_reg;
    jrdp_cmd_t   cmd;
    jrdp_sts_t   sts;
    logic        in_fire;
    logic [3:0]  res_index;
    logic [15:0] pos;
    logic [15:0] vel;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_vel_reg <= MAX_VEL_RESET;
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (wr_en)
        begin
            if (wr_index == REG_MAX_VEL)
                max_vel_reg <= wr_data;
            else
                threshold_reg <= wr_data;
        end
    end

    jrdp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .req_type   (s_axis_tuser),
        .last_joint (s_axis_tlast),
        .in_ready   (s_axis_tready),
        .res_valid  (m_axis_tvalid),
        .res_taken  (m_axis_tready),
        .res_index  (res_index),
        .res_last   (m_axis_tlast),
        .cmd        (cmd),
        .sts        (sts)
    );

    jrdp_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .req_type       (s_axis_tuser),
        .joint_index    (s_axis_tdata[3:0]),
        .joint_position (s_axis_tdata[19:4]),
        .time_us        (s_axis_tdata[51:20]),
        .max_vel        (max_vel_reg),
        .threshold      (threshold_reg),
        .out_position   (pos),
        .out_velocity   (vel),
        .out_reached    (m_axis_tuser)
    );

    assign m_axis_tdata = {4'd0, vel, pos, res_index};

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted while results pending");
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[3:0] == 4'(NUM_JOINTS - 1))
        else $error("last command on wrong joint");
`endif

endmodule
